[rtl/core/c2fsr_pkg.sv]
// ============================================================================
// c2fsr_pkg
// Shared types, codes and constants of the CO2 fan speed regulator.
// ============================================================================
`default_nettype none

package c2fsr_pkg;

    // field widths
    localparam int PPM_W   = 14;
    localparam int SPEED_W = 16;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // control law: speed = SLOPE*(co2-target)/(GOAL_LIMIT-target) + OFFSET
    localparam int SLOPE      = 1000;
    localparam int OFFSET     = 200;
    localparam int GOAL_LIMIT = 2000;

    // divider operand widths: numerator below 16384*1000, divisor 1..2000
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 11;
    localparam int CAND_W    = DIV_NUM_W + 1;

    // reset values of the configuration registers
    localparam logic [PPM_W-1:0]   CRITICAL_RST     = PPM_W'(2000);
    localparam logic [SPEED_W-1:0] FAN_MAX_RST      = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] FAN_MIN_RST      = SPEED_W'(0);
    localparam logic [TICK_W-1:0]  OPEN_TICKS_RST   = TICK_W'(2000);
    localparam logic [TICK_W-1:0]  BLOCK_TICKS_RST  = TICK_W'(60000);
    localparam logic [PPM_W-1:0]   START_TARGET_RST = PPM_W'(900);

    // request operations
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_CO2     = 3'd1,
        OP_FAN_CNT = 3'd2,
        OP_CONTROL = 3'd3,
        OP_TARGET  = 3'd4,
        OP_SPEED   = 3'd5,
        OP_MODE    = 3'd6,
        OP_TICK    = 3'd7
    } c2fsr_op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRITICAL     = 3'd0,
        CFG_FAN_MAX      = 3'd1,
        CFG_FAN_MIN      = 3'd2,
        CFG_OPEN_TICKS   = 3'd3,
        CFG_BLOCK_TICKS  = 3'd4,
        CFG_START_TARGET = 3'd5,
        CFG_START_MANUAL = 3'd6
    } c2fsr_cfg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MULT = 2'd1,
        ST_DIV  = 2'd2
    } c2fsr_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } c2fsr_div_stat_t;

    // clamped speed command
    typedef struct packed {
        logic               send;
        logic [SPEED_W-1:0] speed;
    } c2fsr_cmd_t;

    // mode codes of a mode set request
    localparam logic [15:0] MODE_AUTO   = 16'd0;
    localparam logic [15:0] MODE_MANUAL = 16'd1;

endpackage

`default_nettype wire

[rtl/core/co2_fan_speed_regulator_top.sv]
// ============================================================================
// co2_fan_speed_regulator_top
// CO2 driven fan speed regulator with valve timers and stall detection.
// Timing: a non-divide request has its result registered in the cycle after
//   it is taken. An automatic control step that needs the proportional law
//   runs operand setup, 24 divider iterations and a finish step first.
// Throughput: one request per cycle when results are taken; the divide path
//   blocks new requests until its result is registered.
// Reset: synchronous, active low; clears all but result data; loads defaults.
// ============================================================================
`default_nettype none

module co2_fan_speed_regulator_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [c2fsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [c2fsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [2:0]                         s_op,
    input  wire logic [c2fsr_pkg::PPM_W-1:0]        s_co2_ppm,
    input  wire logic [15:0]                        s_fan_count,
    input  wire logic [c2fsr_pkg::PPM_W-1:0]        s_target_request,
    input  wire logic [c2fsr_pkg::SPEED_W-1:0]      s_speed_request,
    input  wire logic [15:0]                        s_mode_request,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_speed_sent,
    output logic [c2fsr_pkg::SPEED_W-1:0]           m_speed,
    output logic                                    m_valve_open,
    output logic                                    m_spinning,
    output logic                                    m_manual,
    output logic [c2fsr_pkg::PPM_W-1:0]             m_target
);
    import c2fsr_pkg::*;

    // configuration registers
    logic [PPM_W-1:0]   critical_reg;
    logic [SPEED_W-1:0] fan_max_reg;
    logic [SPEED_W-1:0] fan_min_reg;
    logic [TICK_W-1:0]  open_ticks_reg;
    logic [TICK_W-1:0]  block_ticks_reg;
    logic [PPM_W-1:0]   start_target_reg;
    logic               start_manual_reg;

    // regulator state
    logic [PPM_W-1:0]   co2_level_reg,     co2_level_next;
    logic [PPM_W-1:0]   co2_goal_reg,      co2_goal_next;
    logic [SPEED_W-1:0] speed_now_reg,     speed_now_next;
    logic               manual_reg,        manual_next;
    logic               permit_reg,        permit_next;
    logic [15:0]        last_count_reg,    last_count_next;
    logic               turning_reg,       turning_next;
    logic               valve_on_reg,      valve_on_next;
    logic               valve_blocked_reg, valve_blocked_next;
    logic [TICK_W-1:0]  close_timer_reg,   close_timer_next;
    logic [TICK_W-1:0]  block_timer_reg,   block_timer_next;

    // sequencer and result register
    c2fsr_state_t       state_reg, state_next;
    logic               m_valid_reg;
    logic               m_speed_sent_reg;
    logic [SPEED_W-1:0] m_speed_reg;
    logic               m_valve_open_reg;
    logic               m_spinning_reg;
    logic               m_manual_reg;
    logic [PPM_W-1:0]   m_target_reg;

    logic               accept;
    logic               div_needed;
    logic               div_start;
    logic               load_out;
    logic               sent_c;
    c2fsr_op_t          op;
    c2fsr_cmd_t         cmd;
    c2fsr_div_stat_t    div_stat;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_NUM_W-1:0] div_numer;
    logic [DIV_DEN_W-1:0] div_denom;
    logic [PPM_W-1:0]   co2_diff;
    logic [TICK_W-1:0]  open_load;
    logic [TICK_W-1:0]  block_load;

    // clamp a speed candidate to fan_min..fan_max, skip a repeat of a limit
    function automatic c2fsr_cmd_t clamp_speed(
        input logic [CAND_W-1:0]  cand,
        input logic [SPEED_W-1:0] fmax,
        input logic [SPEED_W-1:0] fmin,
        input logic [SPEED_W-1:0] cur
    );
        c2fsr_cmd_t r;
        r.send  = 1'b1;
        r.speed = cand[SPEED_W-1:0];
        if (cand >= CAND_W'(fmax)) begin
            r.send  = (cur != fmax);
            r.speed = fmax;
        end else if (cand <= CAND_W'(fmin)) begin
            r.send  = (cur != fmin);
            r.speed = fmin;
        end
        if (!r.send) begin
            r.speed = cur;
        end
        return r;
    endfunction

    assign op         = c2fsr_op_t'(s_op);
    assign accept     = s_valid && s_ready;
    assign open_load  = (open_ticks_reg == '0) ? TICK_W'(1) : open_ticks_reg;
    assign block_load = (block_ticks_reg == '0) ? TICK_W'(1) : block_ticks_reg;

    // control step that needs the proportional law
    assign div_needed = (op == OP_CONTROL) && !manual_reg
                     && (co2_level_reg < critical_reg)
                     && (co2_level_reg > co2_goal_reg)
                     && (co2_goal_reg < PPM_W'(GOAL_LIMIT));

    // divider operands, registered inside the divider on start
    assign co2_diff  = co2_level_reg - co2_goal_reg;
    assign div_numer = DIV_NUM_W'(co2_diff) * DIV_NUM_W'(SLOPE);
    assign div_denom = DIV_DEN_W'(GOAL_LIMIT) - co2_goal_reg[DIV_DEN_W-1:0];

    c2fsr_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && div_needed) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        div_start = (state_reg == ST_MULT);
    end

    // operation datapath
    always_comb begin
        co2_level_next     = co2_level_reg;
        co2_goal_next      = co2_goal_reg;
        speed_now_next     = speed_now_reg;
        manual_next        = manual_reg;
        permit_next        = permit_reg;
        last_count_next    = last_count_reg;
        turning_next       = turning_reg;
        valve_on_next      = valve_on_reg;
        valve_blocked_next = valve_blocked_reg;
        close_timer_next   = close_timer_reg;
        block_timer_next   = block_timer_reg;
        sent_c             = 1'b0;
        load_out           = 1'b0;
        cmd                = '0;

        if (accept && !div_needed) begin
            load_out = 1'b1;
            unique case (op)
                OP_START: begin
                    co2_goal_next    = start_target_reg;
                    manual_next      = start_manual_reg;
                    speed_now_next   = '0;
                    sent_c           = 1'b1;
                    block_timer_next = block_load;
                end
                OP_CO2: begin
                    co2_level_next = s_co2_ppm;
                end
                OP_FAN_CNT: begin
                    turning_next    = !((s_fan_count == '0) && (last_count_reg == '0));
                    last_count_next = s_fan_count;
                end
                OP_CONTROL: begin
                    if (!manual_reg) begin
                        if (co2_level_reg >= critical_reg) begin
                            speed_now_next = fan_max_reg;
                            sent_c         = 1'b1;
                        end else if (co2_level_reg <= co2_goal_reg) begin
                            // at or below target: minimum speed, open valve once
                            if (!valve_blocked_reg) begin
                                valve_on_next      = 1'b1;
                                valve_blocked_next = 1'b1;
                                close_timer_next   = open_load;
                                block_timer_next   = block_load;
                            end
                            cmd            = clamp_speed('0, fan_max_reg, fan_min_reg,
                                                         speed_now_reg);
                            speed_now_next = cmd.speed;
                            sent_c         = cmd.send;
                        end else begin
                            // target at or above the limit: maximum candidate
                            cmd            = clamp_speed('1, fan_max_reg, fan_min_reg,
                                                         speed_now_reg);
                            speed_now_next = cmd.speed;
                            sent_c         = cmd.send;
                        end
                    end
                end
                OP_TARGET: begin
                    if (!manual_reg && permit_reg) begin
                        permit_next   = 1'b0;
                        co2_goal_next = s_target_request;
                    end
                end
                OP_SPEED: begin
                    if (manual_reg && permit_reg) begin
                        permit_next    = 1'b0;
                        speed_now_next = s_speed_request;
                        sent_c         = 1'b1;
                    end
                end
                OP_MODE: begin
                    permit_next = 1'b1;
                    if (s_mode_request == MODE_AUTO) begin
                        manual_next = 1'b0;
                    end else if (s_mode_request == MODE_MANUAL) begin
                        manual_next = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (close_timer_reg != '0) begin
                        close_timer_next = close_timer_reg - TICK_W'(1);
                        if (close_timer_reg == TICK_W'(1)) begin
                            valve_on_next = 1'b0;
                        end
                    end
                    if (block_timer_reg != '0) begin
                        block_timer_next = block_timer_reg - TICK_W'(1);
                        if (block_timer_reg == TICK_W'(1)) begin
                            valve_blocked_next = 1'b0;
                        end
                    end
                end
            endcase
        end else if ((state_reg == ST_DIV) && div_stat.done) begin
            // proportional law finished: add offset and clamp
            load_out       = 1'b1;
            cmd            = clamp_speed(CAND_W'(div_quot) + CAND_W'(OFFSET),
                                         fan_max_reg, fan_min_reg, speed_now_reg);
            speed_now_next = cmd.speed;
            sent_c         = cmd.send;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            critical_reg     <= CRITICAL_RST;
            fan_max_reg      <= FAN_MAX_RST;
            fan_min_reg      <= FAN_MIN_RST;
            open_ticks_reg   <= OPEN_TICKS_RST;
            block_ticks_reg  <= BLOCK_TICKS_RST;
            start_target_reg <= START_TARGET_RST;
            start_manual_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (c2fsr_cfg_t'(cfg_index))
                CFG_CRITICAL:     critical_reg     <= cfg_wdata[PPM_W-1:0];
                CFG_FAN_MAX:      fan_max_reg      <= cfg_wdata;
                CFG_FAN_MIN:      fan_min_reg      <= cfg_wdata;
                CFG_OPEN_TICKS:   open_ticks_reg   <= cfg_wdata;
                CFG_BLOCK_TICKS:  block_ticks_reg  <= cfg_wdata;
                CFG_START_TARGET: start_target_reg <= cfg_wdata[PPM_W-1:0];
                CFG_START_MANUAL: start_manual_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // regulator state and sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            co2_level_reg     <= '0;
            co2_goal_reg      <= '0;
            speed_now_reg     <= '0;
            manual_reg        <= 1'b0;
            permit_reg        <= 1'b0;
            last_count_reg    <= '0;
            turning_reg       <= 1'b1;
            valve_on_reg      <= 1'b0;
            valve_blocked_reg <= 1'b1;
            close_timer_reg   <= '0;
            block_timer_reg   <= '0;
        end else begin
            state_reg         <= state_next;
            co2_level_reg     <= co2_level_next;
            co2_goal_reg      <= co2_goal_next;
            speed_now_reg     <= speed_now_next;
            manual_reg        <= manual_next;
            permit_reg        <= permit_next;
            last_count_reg    <= last_count_next;
            turning_reg       <= turning_next;
            valve_on_reg      <= valve_on_next;
            valve_blocked_reg <= valve_blocked_next;
            close_timer_reg   <= close_timer_next;
            block_timer_reg   <= block_timer_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, state after the request
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_speed_sent_reg <= sent_c;
            m_speed_reg      <= speed_now_next;
            m_valve_open_reg <= valve_on_next;
            m_spinning_reg   <= turning_next;
            m_manual_reg     <= manual_next;
            m_target_reg     <= co2_goal_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_speed_sent = m_speed_sent_reg;
    assign m_speed      = m_speed_reg;
    assign m_valve_open = m_valve_open_reg;
    assign m_spinning   = m_spinning_reg;
    assign m_manual     = m_manual_reg;
    assign m_target     = m_target_reg;

`ifndef SYNTHESIS
    // the divider runs only while the sequencer waits on it
    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide state");

    // no result is held while a divide request is in flight
    a_no_result_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending during a divide request");

    // the valve is open exactly while its close timer runs
    a_valve_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        valve_on_reg == (close_timer_reg != '0))
        else $error("valve state and close timer disagree");
`endif

endmodule

`default_nettype wire

[rtl/core/c2fsr_div.sv]
// ============================================================================
// c2fsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module c2fsr_div #(
    parameter int NUM_W = c2fsr_pkg::DIV_NUM_W,
    parameter int DEN_W = c2fsr_pkg::DIV_DEN_W
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [NUM_W-1:0]          numer,
    input  wire logic [DEN_W-1:0]          denom,
    output c2fsr_pkg::c2fsr_div_stat_t     stat,
    output logic [NUM_W-1:0]               quot
);
    import c2fsr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;

    // one trial subtraction of the shifted remainder
    always_comb begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        if (!diff[DEN_W]) begin
            rem_next = diff[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    // control: iteration count and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

`ifndef SYNTHESIS
    // a finished quotient always follows a running division
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for the CO2 fan speed regulator. A shadow of the
// regulator state predicts the status returned for every request, and each
// returned status is compared field by field in arrival order. Directed
// requests cover reset defaults, the control law limits, the valve timers,
// the change permit and register extremes. Random traffic then runs under
// several register settings, mostly as well-formed request sequences. Both
// handshakes stall at random, except in the gap-free random phase.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import c2fsr_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE = 190;
    // quiet stretch of a correct run: divide + stalls + settle + register
    // writes stays far below this
    localparam int WATCHDOG_LIMIT  = 3000;

    // proportional law constants
    localparam longint unsigned LAW_GAIN    = 1000;
    localparam longint unsigned LAW_BASE    = 200;
    localparam longint unsigned LAW_CEILING = 2000;

    typedef struct packed {
        c2fsr_op_t          op;
        logic [PPM_W-1:0]   co2_ppm;
        logic [15:0]        fan_count;
        logic [PPM_W-1:0]   target_req;
        logic [SPEED_W-1:0] speed_req;
        logic [15:0]        mode_req;
    } fan_request_t;

    typedef struct packed {
        logic               speed_sent;
        logic [SPEED_W-1:0] speed;
        logic               valve_open;
        logic               spinning;
        logic               manual;
        logic [PPM_W-1:0]   target;
    } fan_status_t;

    // block ports
    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    c2fsr_cfg_t            cfg_index = CFG_CRITICAL;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    c2fsr_op_t             s_op = OP_START;
    logic [PPM_W-1:0]      s_co2_ppm = '0;
    logic [15:0]           s_fan_count = '0;
    logic [PPM_W-1:0]      s_target_request = '0;
    logic [SPEED_W-1:0]    s_speed_request = '0;
    logic [15:0]           s_mode_request = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_speed_sent;
    logic [SPEED_W-1:0]    m_speed;
    logic                  m_valve_open;
    logic                  m_spinning;
    logic                  m_manual;
    logic [PPM_W-1:0]      m_target;

    // shadow registers
    logic [PPM_W-1:0]   reg_critical     = CRITICAL_RST;
    logic [SPEED_W-1:0] reg_fan_max      = FAN_MAX_RST;
    logic [SPEED_W-1:0] reg_fan_min      = FAN_MIN_RST;
    logic [TICK_W-1:0]  reg_open_ticks   = OPEN_TICKS_RST;
    logic [TICK_W-1:0]  reg_block_ticks  = BLOCK_TICKS_RST;
    logic [PPM_W-1:0]   reg_start_target = START_TARGET_RST;
    logic               reg_start_manual = 1'b0;

    // shadow regulator state
    logic [PPM_W-1:0]   level_ppm    = '0;
    logic [PPM_W-1:0]   goal_ppm     = '0;
    logic [SPEED_W-1:0] fan_cmd      = '0;
    logic               in_manual    = 1'b0;
    logic               permit_armed = 1'b0;
    logic [15:0]        prev_count   = '0;
    logic               fan_ok       = 1'b1;
    logic               valve_driven = 1'b0;
    logic               valve_locked = 1'b1;
    logic [TICK_W-1:0]  close_cnt    = '0;
    logic [TICK_W-1:0]  lock_cnt     = '0;

    fan_status_t expected_status_q[$];
    int          error_count  = 0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    logic        steady_flow  = 1'b0;

    co2_fan_speed_regulator_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_co2_ppm        (s_co2_ppm),
        .s_fan_count      (s_fan_count),
        .s_target_request (s_target_request),
        .s_speed_request  (s_speed_request),
        .s_mode_request   (s_mode_request),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_speed_sent     (m_speed_sent),
        .m_speed          (m_speed),
        .m_valve_open     (m_valve_open),
        .m_spinning       (m_spinning),
        .m_manual         (m_manual),
        .m_target         (m_target)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // a zero tick count is loaded as one
    function automatic logic [TICK_W-1:0] load_ticks(logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // advance the shadow state by one request and return the status it gives
    function automatic fan_status_t predict_fan_status(fan_request_t rq);
        fan_status_t     st;
        longint unsigned demand;
        logic            sent;
        sent   = 1'b0;
        demand = 0;
        case (rq.op)
            OP_START: begin
                goal_ppm  = reg_start_target;
                in_manual = reg_start_manual;
                fan_cmd   = '0;
                sent      = 1'b1;
                lock_cnt  = load_ticks(reg_block_ticks);
            end
            OP_CO2: level_ppm = rq.co2_ppm;
            OP_FAN_CNT: begin
                fan_ok     = !(rq.fan_count == '0 && prev_count == '0);
                prev_count = rq.fan_count;
            end
            OP_CONTROL: begin
                if (!in_manual && level_ppm >= reg_critical) begin
                    fan_cmd = reg_fan_max;
                    sent    = 1'b1;
                end else if (!in_manual) begin
                    // demand: zero at or below goal, saturated with the goal at or past the ceiling
                    if (level_ppm <= goal_ppm) begin
                        demand = 0;
                        if (!valve_locked) begin
                            valve_driven = 1'b1;
                            valve_locked = 1'b1;
                            close_cnt    = load_ticks(reg_open_ticks);
                            lock_cnt     = load_ticks(reg_block_ticks);
                        end
                    end else if (goal_ppm >= LAW_CEILING) begin
                        demand = '1;
                    end else begin
                        demand = LAW_GAIN * (64'(level_ppm) - 64'(goal_ppm))
                                 / (LAW_CEILING - 64'(goal_ppm)) + LAW_BASE;
                    end
                    // clamp, upper limit first; nothing sent when already at the limit
                    if (demand >= 64'(reg_fan_max)) begin
                        if (fan_cmd != reg_fan_max) begin
                            fan_cmd = reg_fan_max;
                            sent    = 1'b1;
                        end
                    end else if (demand <= 64'(reg_fan_min)) begin
                        if (fan_cmd != reg_fan_min) begin
                            fan_cmd = reg_fan_min;
                            sent    = 1'b1;
                        end
                    end else begin
                        fan_cmd = SPEED_W'(demand);
                        sent    = 1'b1;
                    end
                end
            end
            OP_TARGET: begin
                if (!in_manual && permit_armed) begin
                    permit_armed = 1'b0;
                    goal_ppm     = rq.target_req;
                end
            end
            OP_SPEED: begin
                if (in_manual && permit_armed) begin
                    permit_armed = 1'b0;
                    fan_cmd      = rq.speed_req;
                    sent         = 1'b1;
                end
            end
            OP_MODE: begin
                permit_armed = 1'b1;
                if (rq.mode_req == MODE_AUTO) begin
                    in_manual = 1'b0;
                end else if (rq.mode_req == MODE_MANUAL) begin
                    in_manual = 1'b1;
                end
            end
            OP_TICK: begin
                if (close_cnt != '0) begin
                    close_cnt = close_cnt - 1'b1;
                    if (close_cnt == '0) valve_driven = 1'b0;
                end
                if (lock_cnt != '0) begin
                    lock_cnt = lock_cnt - 1'b1;
                    if (lock_cnt == '0) valve_locked = 1'b0;
                end
            end
            default: ;
        endcase
        st.speed_sent = sent;
        st.speed      = fan_cmd;
        st.valve_open = valve_driven;
        st.spinning   = fan_ok;
        st.manual     = in_manual;
        st.target     = goal_ppm;
        return st;
    endfunction

    // drive one request, hold it until taken, then record its status
    task automatic send_request(fan_request_t rq);
        @(negedge aclk);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= rq.op;
        s_co2_ppm        <= rq.co2_ppm;
        s_fan_count      <= rq.fan_count;
        s_target_request <= rq.target_req;
        s_speed_request  <= rq.speed_req;
        s_mode_request   <= rq.mode_req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_status_q.push_back(predict_fan_status(rq));
        items_sent++;
    endtask

    // request with random payload; the operation's own field gets value
    task automatic send_op(c2fsr_op_t op, logic [15:0] value);
        fan_request_t rq;
        rq.op         = op;
        rq.co2_ppm    = PPM_W'($urandom);
        rq.fan_count  = 16'($urandom);
        rq.target_req = PPM_W'($urandom);
        rq.speed_req  = SPEED_W'($urandom);
        rq.mode_req   = 16'($urandom);
        case (op)
            OP_CO2:     rq.co2_ppm    = value[PPM_W-1:0];
            OP_FAN_CNT: rq.fan_count  = value;
            OP_TARGET:  rq.target_req = value[PPM_W-1:0];
            OP_SPEED:   rq.speed_req  = value;
            OP_MODE:    rq.mode_req   = value;
            default: ;
        endcase
        send_request(rq);
    endtask

    // stop requesting and wait for every outstanding status
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // one register write, block idle
    task automatic write_reg(c2fsr_cfg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CRITICAL:     reg_critical     = data[PPM_W-1:0];
            CFG_FAN_MAX:      reg_fan_max      = data;
            CFG_FAN_MIN:      reg_fan_min      = data;
            CFG_OPEN_TICKS:   reg_open_ticks   = data;
            CFG_BLOCK_TICKS:  reg_block_ticks  = data;
            CFG_START_TARGET: reg_start_target = data[PPM_W-1:0];
            CFG_START_MANUAL: reg_start_manual = data[0];
            default: ;
        endcase
    endtask

    // random settings, short valve timers so the valve cycles often
    task automatic pick_random_settings();
        int unsigned     roll;
        logic [PPM_W-1:0] ppm;
        logic [15:0]     val;
        roll = $urandom_range(99);
        if (roll < 70)      ppm = PPM_W'($urandom_range(1000, 16383));
        else if (roll < 85) ppm = PPM_W'($urandom_range(0, 2000));
        else                ppm = '1;
        write_reg(CFG_CRITICAL, {2'($urandom), ppm});
        roll = $urandom_range(99);
        if (roll < 60)      val = 16'($urandom_range(300, 2000));
        else if (roll < 80) val = 16'($urandom);
        else                val = 16'hFFFF;
        write_reg(CFG_FAN_MAX, val);
        roll = $urandom_range(99);
        val = (roll < 70) ? 16'($urandom_range(0, 400)) : 16'($urandom);
        write_reg(CFG_FAN_MIN, val);
        write_reg(CFG_OPEN_TICKS, 16'($urandom_range(0, 6)));
        write_reg(CFG_BLOCK_TICKS, 16'($urandom_range(0, 10)));
        roll = $urandom_range(99);
        ppm = (roll < 70) ? PPM_W'($urandom_range(0, 1999)) : PPM_W'($urandom);
        write_reg(CFG_START_TARGET, {2'($urandom), ppm});
        roll = $urandom_range(99);
        write_reg(CFG_START_MANUAL, {15'($urandom), (roll >= 75)});
    endtask

    // co2 reading placed around the goal and the critical level
    function automatic logic [15:0] pick_co2();
        int c;
        case ($urandom_range(4))
            0, 1:    c = int'(goal_ppm) + int'($urandom_range(1, 2200));
            2:       c = int'($urandom_range(0, goal_ppm));
            3:       c = int'(reg_critical) + int'($urandom_range(0, 2)) - 1;
            default: c = int'($urandom_range(0, 16383));
        endcase
        if (c < 0) c = 0;
        if (c > 16383) c = 16383;
        return 16'(c);
    endfunction

    // reset defaults: control law, stall detection, permit
    task automatic test_defaults();
        send_op(OP_CONTROL, '0);
        send_op(OP_START, '0);
        send_op(OP_CO2, 16'h3FFF);
        send_op(OP_CONTROL, '0);
        send_op(OP_CO2, 16'd1500);
        send_op(OP_CONTROL, '0);
        send_op(OP_CO2, 16'd0);
        send_op(OP_CONTROL, '0);
        send_op(OP_FAN_CNT, 16'h0000);
        send_op(OP_FAN_CNT, 16'hFFFF);
        send_op(OP_FAN_CNT, 16'h0000);
        send_op(OP_MODE, 16'hFFFF);
        send_op(OP_SPEED, 16'hFFFF);
        send_op(OP_TARGET, 16'h3FFF);
    endtask

    // register extremes, zero tick counts, goal past the ceiling, min above max
    task automatic test_register_extremes();
        drain_results();
        write_reg(CFG_CRITICAL, 16'hFFFF);
        write_reg(CFG_FAN_MAX, 16'hFFFF);
        write_reg(CFG_FAN_MIN, 16'h0000);
        write_reg(CFG_OPEN_TICKS, 16'h0000);
        write_reg(CFG_BLOCK_TICKS, 16'h0000);
        write_reg(CFG_START_TARGET, 16'hFFFF);
        write_reg(CFG_START_MANUAL, 16'hFFFE);
        send_op(OP_START, '0);
        send_op(OP_TICK, '0);
        send_op(OP_CO2, 16'd5000);
        send_op(OP_CONTROL, '0);
        send_op(OP_TICK, '0);
        send_op(OP_MODE, MODE_AUTO);
        send_op(OP_TARGET, 16'd2000);
        send_op(OP_CONTROL, '0);
        send_op(OP_CONTROL, '0);
        drain_results();
        write_reg(CFG_FAN_MAX, 16'h0000);
        write_reg(CFG_FAN_MIN, 16'hFFFF);
        write_reg(CFG_START_MANUAL, 16'h0001);
        send_op(OP_CONTROL, '0);
        send_op(OP_START, '0);
    endtask

    // random request sequences under random settings
    task automatic test_random_traffic(int n_items, logic no_gaps);
        int stop_at;
        int pick;
        drain_results();
        pick_random_settings();
        steady_flow = no_gaps;
        stop_at = items_sent + n_items;
        send_op(OP_START, '0);
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_op(OP_CO2, pick_co2());
                send_op(OP_CONTROL, '0);
            end else if (pick < 50) begin
                send_op(OP_MODE, MODE_AUTO);
                send_op(OP_TARGET, ($urandom_range(99) < 70) ?
                        16'($urandom_range(0, 2400)) : 16'($urandom));
            end else if (pick < 58) begin
                send_op(OP_MODE, MODE_MANUAL);
                send_op(OP_SPEED, 16'($urandom));
                if ($urandom_range(1)) send_op(OP_CONTROL, '0);
                send_op(OP_MODE, MODE_AUTO);
            end else if (pick < 68) begin
                send_op(OP_FAN_CNT, $urandom_range(1) ? 16'h0000 : 16'($urandom));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 12)) send_op(OP_TICK, '0);
            end else if (pick < 85) begin
                send_op(OP_START, '0);
            end else begin
                send_op(c2fsr_op_t'($urandom_range(7)), 16'($urandom));
            end
            // occasional full drain before going on
            if ($urandom_range(99) < 2) drain_results();
        end
        drain_results();
        steady_flow = 1'b0;
    endtask

    // result side stalls at random, except during gap-free traffic
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // compare each returned status with the oldest prediction
    always @(posedge aclk) begin : status_check
        fan_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t ns: status with no request pending, expected none, actual speed %0d",
                         $time, m_speed);
                error_count++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("speed_sent", want.speed_sent, m_speed_sent);
                check_field("speed", want.speed, m_speed);
                check_field("valve_open", want.valve_open, m_valve_open);
                check_field("spinning", want.spinning, m_spinning);
                check_field("manual", want.manual, m_manual);
                check_field("target", want.target, m_target);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_register_extremes();
        test_random_traffic(ITEMS_PER_PHASE, 1'b0);
        test_random_traffic(ITEMS_PER_PHASE, 1'b1);
        test_random_traffic(ITEMS_PER_PHASE, 1'b0);
        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
